// ----- rtl/fbw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbw_pkg
// Shared types and constants of the line write framer.
// ----------------------------------------------------------------------------
package fbw_pkg;

  localparam int WIDTH_PIXELS_DEF = 1024;
  localparam int HEIGHT_LINES_DEF = 768;
  localparam int CHUNK_WORDS_DEF  = 256;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [7:0] START_BYTE_RST    = 8'd175;
  localparam logic [7:0] WRITE_COMMAND_RST = 8'd104;

  // configuration register indexes
  localparam logic CFG_START_BYTE    = 1'b0;
  localparam logic CFG_WRITE_COMMAND = 1'b1;

  // item operations
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // byte slots of one command
  localparam logic [2:0] BYTE_START   = 3'd0;
  localparam logic [2:0] BYTE_CMD     = 3'd1;
  localparam logic [2:0] BYTE_ADDR_HI = 3'd2;
  localparam logic [2:0] BYTE_ADDR_MD = 3'd3;
  localparam logic [2:0] BYTE_ADDR_LO = 3'd4;
  localparam logic [2:0] BYTE_COUNT   = 3'd5;
  localparam logic [2:0] BYTE_PIX_LO  = 3'd6;
  localparam logic [2:0] BYTE_PIX_HI  = 3'd7;

  typedef struct packed {
    logic        hdr;
    logic [23:0] addr;
    logic [7:0]  words;
    logic [15:0] pixel;
  } fbw_entry_t;

endpackage
`default_nettype wire

// ----- rtl/fbw_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbw_front
// Accepts items, clips lines, tracks chunks and queues pixel work.
// ----------------------------------------------------------------------------
module fbw_front #(
  parameter int WIDTH_PIXELS = fbw_pkg::WIDTH_PIXELS_DEF,
  parameter int HEIGHT_LINES = fbw_pkg::HEIGHT_LINES_DEF,
  parameter int CHUNK_WORDS  = fbw_pkg::CHUNK_WORDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_op,
  input  wire logic [11:0]        in_column,
  input  wire logic [11:0]        in_row,
  input  wire logic [12:0]        in_pixel_count,
  input  wire logic [15:0]        in_pixel_word,
  input  wire logic               q_full,
  output logic                    push,
  output fbw_pkg::fbw_entry_t     push_entry
);

  logic [12:0] pixels_remaining_r, pixels_remaining_nxt;
  logic [8:0]  chunk_words_left_r, chunk_words_left_nxt;
  logic [23:0] byte_address_r, byte_address_nxt;
  logic        accept;
  logic [13:0] end_col;
  logic [12:0] clip_cnt;
  logic [24:0] lin_addr;
  logic [8:0]  words;
  logic        need_hdr;

  assign accept = in_valid && !q_full;
  assign end_col = 14'(in_column) + 14'(in_pixel_count);
  assign lin_addr = 25'(in_row) * 25'(WIDTH_PIXELS) + 25'(in_column);
  assign need_hdr = (chunk_words_left_r == 9'd0);
  assign words = (pixels_remaining_r > 13'(CHUNK_WORDS)) ? 9'(CHUNK_WORDS)
                                                         : pixels_remaining_r[8:0];

  always_comb begin
    if (13'(in_row) >= 13'(HEIGHT_LINES) || 13'(in_column) >= 13'(WIDTH_PIXELS)) begin
      clip_cnt = 13'd0;
    end else if (end_col > 14'(WIDTH_PIXELS)) begin
      clip_cnt = 13'(WIDTH_PIXELS) - 13'(in_column);
    end else begin
      clip_cnt = in_pixel_count;
    end
  end

  assign push = accept && (in_op == fbw_pkg::OP_PIXEL) && (pixels_remaining_r != 13'd0);

  always_comb begin
    push_entry.hdr   = need_hdr;
    push_entry.addr  = byte_address_r;
    push_entry.words = words[7:0];
    push_entry.pixel = in_pixel_word;
  end

  always_comb begin
    pixels_remaining_nxt = pixels_remaining_r;
    chunk_words_left_nxt = chunk_words_left_r;
    byte_address_nxt     = byte_address_r;
    if (accept && (in_op == fbw_pkg::OP_BEGIN)) begin
      pixels_remaining_nxt = clip_cnt;
      chunk_words_left_nxt = 9'd0;
      byte_address_nxt     = {lin_addr[22:0], 1'b0};
    end else if (push) begin
      pixels_remaining_nxt = pixels_remaining_r - 13'd1;
      chunk_words_left_nxt = (need_hdr ? words : chunk_words_left_r) - 9'd1;
      byte_address_nxt     = byte_address_r + 24'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_remaining_r <= 13'd0;
      chunk_words_left_r <= 9'd0;
      byte_address_r     <= 24'd0;
    end else begin
      pixels_remaining_r <= pixels_remaining_nxt;
      chunk_words_left_r <= chunk_words_left_nxt;
      byte_address_r     <= byte_address_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_chunk_le_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (pixels_remaining_r == 13'd0) |-> (chunk_words_left_r == 9'd0))
    else $error("chunk words left without pixels remaining");
`endif

endmodule
`default_nettype wire

// ----- rtl/fbw_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbw_queue
// Short queue of pixel work between the front and back parts.
// ----------------------------------------------------------------------------
module fbw_queue #(
  parameter int DEPTH = fbw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire fbw_pkg::fbw_entry_t push_entry,
  input  wire logic                pop,
  output logic                     full,
  output logic                     q_valid,
  output fbw_pkg::fbw_entry_t      head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  fbw_pkg::fbw_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count over depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !q_valid))
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ----- rtl/fbw_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbw_back
// Serializes queued pixel work into command bytes, one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module fbw_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire fbw_pkg::fbw_entry_t head,
  input  wire logic [7:0]          start_byte,
  input  wire logic [7:0]          write_command,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_byte,
  output logic                     out_last_of_run
);

  logic [2:0] idx_r, idx_nxt;
  logic [2:0] cur_idx;
  logic       advance;
  logic [7:0] sel_byte;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  // entries without a header start at the data bytes
  assign cur_idx = (idx_r == fbw_pkg::BYTE_START && !head.hdr) ? fbw_pkg::BYTE_PIX_LO
                                                                : idx_r;
  assign advance = q_valid && (!out_valid_r || !out_stall);
  assign pop     = advance && (cur_idx == fbw_pkg::BYTE_PIX_HI);

  always_comb begin
    case (cur_idx)
      fbw_pkg::BYTE_START:   sel_byte = start_byte;
      fbw_pkg::BYTE_CMD:     sel_byte = write_command;
      fbw_pkg::BYTE_ADDR_HI: sel_byte = head.addr[23:16];
      fbw_pkg::BYTE_ADDR_MD: sel_byte = head.addr[15:8];
      fbw_pkg::BYTE_ADDR_LO: sel_byte = head.addr[7:0];
      fbw_pkg::BYTE_COUNT:   sel_byte = head.words;
      fbw_pkg::BYTE_PIX_LO:  sel_byte = head.pixel[7:0];
      fbw_pkg::BYTE_PIX_HI:  sel_byte = head.pixel[15:8];
      default:               sel_byte = 8'h00;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (advance) begin
      idx_nxt = (cur_idx == fbw_pkg::BYTE_PIX_HI) ? fbw_pkg::BYTE_START : cur_idx + 3'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= fbw_pkg::BYTE_START;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= sel_byte;
      out_last_r <= (cur_idx == fbw_pkg::BYTE_PIX_HI);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

`ifndef NO_ASSERTIONS
  a_mid_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != fbw_pkg::BYTE_START) |-> q_valid)
    else $error("entry left queue while being serialized");
  a_hdr_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cur_idx != fbw_pkg::BYTE_PIX_HI) |=> (idx_r == $past(cur_idx) + 3'd1))
    else $error("byte slot skipped");
`endif

endmodule
`default_nettype wire

// ----- rtl/framebuffer_line_write_framer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// framebuffer_line_write_framer_core
// Frames lines of 16-bit pixels into raw-write command bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): in_op = 0 begins a line with
//   in_column, in_row, in_pixel_count; in_op = 1 carries one pixel. A begin
//   item and a pixel beyond the clipped count produce no output.
//   Output channel (out_valid / out_stall): command bytes, with
//   out_last_of_run marking the final byte caused by an input pixel.
//   Config port: cfg_we, cfg_index, cfg_data; write only while idle.
// Timing:
//   With the queue empty, the first byte of a pixel passes through the queue
//   and then the output register. A pixel yields 2 output bytes, 8 when it
//   opens a chunk (six header bytes); the output register sends one byte per
//   cycle while out_stall is low. A four-entry queue lets the input run ahead,
//   so items are taken every cycle until it fills.
// Reset:
//   Registers return to 175 / 104, line state clears, queue empties.
// Stall:
//   A stalled byte holds; the queue fills and then in_stall rises.
// ----------------------------------------------------------------------------
module framebuffer_line_write_framer_core #(
  parameter int WIDTH_PIXELS = fbw_pkg::WIDTH_PIXELS_DEF,
  parameter int HEIGHT_LINES = fbw_pkg::HEIGHT_LINES_DEF,
  parameter int CHUNK_WORDS  = fbw_pkg::CHUNK_WORDS_DEF,
  parameter int QUEUE_DEPTH  = fbw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [11:0] in_column,
  input  wire logic [11:0] in_row,
  input  wire logic [12:0] in_pixel_count,
  input  wire logic [15:0] in_pixel_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last_of_run
);

  logic [7:0] start_byte_r, start_byte_nxt;
  logic [7:0] write_command_r, write_command_nxt;
  logic       q_full;
  logic       q_valid;
  logic       push;
  logic       pop;
  fbw_pkg::fbw_entry_t push_entry;
  fbw_pkg::fbw_entry_t head;

  always_comb begin
    start_byte_nxt    = start_byte_r;
    write_command_nxt = write_command_r;
    if (cfg_we) begin
      case (cfg_index)
        fbw_pkg::CFG_START_BYTE:    start_byte_nxt = cfg_data;
        fbw_pkg::CFG_WRITE_COMMAND: write_command_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r    <= fbw_pkg::START_BYTE_RST;
      write_command_r <= fbw_pkg::WRITE_COMMAND_RST;
    end else begin
      start_byte_r    <= start_byte_nxt;
      write_command_r <= write_command_nxt;
    end
  end

  assign in_stall = q_full;

  fbw_front #(
    .WIDTH_PIXELS (WIDTH_PIXELS),
    .HEIGHT_LINES (HEIGHT_LINES),
    .CHUNK_WORDS  (CHUNK_WORDS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_op          (in_op),
    .in_column      (in_column),
    .in_row         (in_row),
    .in_pixel_count (in_pixel_count),
    .in_pixel_word  (in_pixel_word),
    .q_full         (q_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  fbw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .q_valid    (q_valid),
    .head       (head)
  );

  fbw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .head            (head),
    .start_byte      (start_byte_r),
    .write_command   (write_command_r),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line write framer core.
// Random valid/stall traffic drives begin and pixel items. Each accepted item
// goes through an in-bench framer model, and every output byte is checked in
// order. The bench writes the start and command registers only while the core
// is idle.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SETTLE_CYCLES = 20;
  localparam int STUCK_LIMIT   = 4000;

  typedef struct {
    logic        op;
    logic [11:0] column;
    logic [11:0] row;
    logic [12:0] count;
    logic [15:0] word;
  } line_item_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } framed_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = fbw_pkg::CFG_START_BYTE;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = fbw_pkg::OP_BEGIN;
  logic [11:0] in_column = 12'd0;
  logic [11:0] in_row = 12'd0;
  logic [12:0] in_pixel_count = 13'd0;
  logic [15:0] in_pixel_word = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [7:0]  out_byte;
  logic        out_last_of_run;

  line_item_t   line_items[$];
  framed_byte_t expected_bytes[$];

  logic        quiet = 1'b0;
  logic        in_taken = 1'b0;
  int          error_count = 0;
  int          stuck_cycles = 0;
  int          pushed_items = 0;

  // framer model state
  logic [7:0]  reg_start = fbw_pkg::START_BYTE_RST;
  logic [7:0]  reg_cmd = fbw_pkg::WRITE_COMMAND_RST;
  logic [12:0] line_left = '0;
  logic [8:0]  chunk_left = '0;
  logic [23:0] fb_addr = '0;

  framebuffer_line_write_framer_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_column       (in_column),
    .in_row          (in_row),
    .in_pixel_count  (in_pixel_count),
    .in_pixel_word   (in_pixel_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic expect_byte(input logic [7:0] value, input logic last);
    framed_byte_t fb;
    fb.value = value;
    fb.last = last;
    expected_bytes.push_back(fb);
  endtask

  task automatic frame_item(input line_item_t it);
    int unsigned clip;
    int unsigned words;
    int unsigned addr_full;
    if (it.op == fbw_pkg::OP_BEGIN) begin
      clip = it.count;
      if (it.row >= fbw_pkg::HEIGHT_LINES_DEF || it.column >= fbw_pkg::WIDTH_PIXELS_DEF) begin
        clip = 0;
      end else if (int'(it.column) + clip > fbw_pkg::WIDTH_PIXELS_DEF) begin
        clip = fbw_pkg::WIDTH_PIXELS_DEF - int'(it.column);
      end
      addr_full = (int'(it.row) * fbw_pkg::WIDTH_PIXELS_DEF + int'(it.column)) * 2;
      line_left = clip[12:0];
      chunk_left = '0;
      fb_addr = addr_full[23:0];
    end else if (line_left != 0) begin
      if (chunk_left == 0) begin
        words = (line_left > fbw_pkg::CHUNK_WORDS_DEF) ? fbw_pkg::CHUNK_WORDS_DEF : line_left;
        expect_byte(reg_start, 1'b0);
        expect_byte(reg_cmd, 1'b0);
        expect_byte(fb_addr[23:16], 1'b0);
        expect_byte(fb_addr[15:8], 1'b0);
        expect_byte(fb_addr[7:0], 1'b0);
        expect_byte(words[7:0], 1'b0);
        chunk_left = words[8:0];
      end
      expect_byte(it.word[7:0], 1'b0);
      expect_byte(it.word[15:8], 1'b1);
      fb_addr = fb_addr + 24'd2;
      line_left = line_left - 13'd1;
      chunk_left = chunk_left - 9'd1;
    end
  endtask

  // input driver
  always @(negedge clk) begin
    line_item_t nxt;
    out_stall <= !quiet && ($urandom_range(99) < 37);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (line_items.size() != 0 && (quiet || $urandom_range(99) >= 37)) begin
        nxt = line_items.pop_front();
        in_valid <= 1'b1;
        in_op <= nxt.op;
        in_column <= nxt.column;
        in_row <= nxt.row;
        in_pixel_count <= nxt.count;
        in_pixel_word <= nxt.word;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    line_item_t it;
    framed_byte_t fb;
    in_taken = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == fbw_pkg::CFG_START_BYTE) begin
          reg_start = cfg_data;
        end else begin
          reg_cmd = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        it.op = in_op;
        it.column = in_column;
        it.row = in_row;
        it.count = in_pixel_count;
        it.word = in_pixel_word;
        frame_item(it);
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                   $time, out_byte, out_last_of_run);
        end else begin
          fb = expected_bytes.pop_front();
          if (out_byte !== fb.value || out_last_of_run !== fb.last) begin
            error_count++;
            $display("%0t: byte mismatch: expected %02h last %0b, actual %02h last %0b",
                     $time, fb.value, fb.last, out_byte, out_last_of_run);
          end
        end
      end
      if (in_taken || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
          $display("testbench: done, errors");
          $finish;
        end
      end
    end
  end

  task automatic push_item(input line_item_t it);
    line_items.push_back(it);
    pushed_items++;
  endtask

  task automatic push_begin(input int col, input int row, input int cnt);
    line_item_t it;
    it.op = fbw_pkg::OP_BEGIN;
    it.column = col[11:0];
    it.row = row[11:0];
    it.count = cnt[12:0];
    it.word = 16'($urandom);
    push_item(it);
  endtask

  task automatic push_pixel(input logic [15:0] word);
    line_item_t it;
    it.op = fbw_pkg::OP_PIXEL;
    it.column = 12'($urandom);
    it.row = 12'($urandom);
    it.count = 13'($urandom);
    it.word = word;
    push_item(it);
  endtask

  task automatic push_noise();
    line_item_t it;
    it.op = 1'($urandom);
    it.column = 12'($urandom);
    it.row = 12'($urandom);
    it.count = 13'($urandom);
    it.word = 16'($urandom);
    push_item(it);
  endtask

  task automatic push_random_line();
    int col;
    int row;
    int cnt;
    int npix;
    case ($urandom_range(3))
      0, 1: col = $urandom_range(1023);
      2: col = $urandom_range(1023, 1000);
      default: col = $urandom_range(4095);
    endcase
    row = ($urandom_range(6) == 0) ? $urandom_range(4095) : $urandom_range(767);
    case ($urandom_range(9))
      7: cnt = $urandom_range(3);
      8, 9: cnt = $urandom_range(8191);
      default: cnt = $urandom_range(12, 1);
    endcase
    npix = ((cnt > 14) ? 14 : cnt) + $urandom_range(2);
    if ($urandom_range(4) == 0) npix = $urandom_range(npix);
    push_begin(col, row, cnt);
    repeat (npix) push_pixel(16'($urandom));
  endtask

  task automatic wait_results();
    while (line_items.size() != 0 || in_valid || expected_bytes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_lines(input int count);
    int stop_at;
    stop_at = pushed_items + count;
    while (pushed_items < stop_at) begin
      if ($urandom_range(9) == 0) begin
        push_noise();
      end else begin
        push_random_line();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset register values, clipping and drop cases
    push_begin(0, 0, 3);
    push_pixel(16'h0000);
    push_pixel(16'hFFFF);
    push_pixel(16'hA55A);
    push_pixel(16'h1234);
    push_begin(0, 768, 5);
    push_pixel(16'h5555);
    push_begin(1024, 0, 5);
    push_pixel(16'hAAAA);
    push_begin(1020, 10, 10);
    repeat (5) push_pixel(16'($urandom));
    push_begin(4095, 4095, 8191);
    push_pixel(16'hFFFF);
    push_begin(1023, 767, 8191);
    push_pixel(16'h8001);
    push_pixel(16'h7FFE);
    push_begin(5, 100, 4096);
    push_pixel(16'h00FF);
    push_pixel(16'hFF00);
    push_begin(0, 1, 2);
    push_pixel(16'h0F0F);
    settle();

    // one long line, no idling
    write_reg(fbw_pkg::CFG_START_BYTE, 8'h00);
    write_reg(fbw_pkg::CFG_WRITE_COMMAND, 8'hFF);
    quiet = 1'b1;
    push_begin(700, 767, 80);
    repeat (81) push_pixel(16'($urandom));
    settle();
    quiet = 1'b0;

    // random lines; sender holds mid-line until the output drains
    write_reg(fbw_pkg::CFG_START_BYTE, 8'hFF);
    write_reg(fbw_pkg::CFG_WRITE_COMMAND, 8'h00);
    push_begin(200, 300, 10);
    repeat (5) push_pixel(16'($urandom));
    wait_results();
    repeat (5) push_pixel(16'($urandom));
    random_lines(60);
    settle();

    write_reg(fbw_pkg::CFG_START_BYTE, 8'($urandom));
    write_reg(fbw_pkg::CFG_WRITE_COMMAND, 8'($urandom));
    random_lines(60);
    settle();

    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
